// ===== hdl/hb64_pkg.sv =====
// Shared types, constants and character lookup functions for the
// hex/base64 value decoder. No dependencies.
package hb64_pkg;

    // Decode mode register codes; the fourth code behaves as plain text.
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_BASE64 = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_RESET  = MODE_BASE64;

    // Status codes reported on the final beat of a value.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
    localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

    // Special base64 characters.
    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

    // Result queue sizing, counted in decoded groups.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One group of results caused by a single input character.
    typedef struct packed {
        logic [2:0][7:0] bytes;      // decoded bytes, entry 0 goes out first
        logic [1:0]      beats;      // number of output beats, 1 to 3
        logic            has_byte;   // zero for an end marker without data
        logic            value_end;  // group closes the value
        logic [1:0]      status;     // final status, valid with value_end
    } group_t;

    // Base64 alphabet lookup: bit 6 set means not in the alphabet.
    function automatic logic [6:0] b64_lookup(input logic [7:0] c);
        logic [7:0] d;
        logic       bad;
        d   = 8'd0;
        bad = 1'b0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
        end else if (c == CHAR_PLUS) begin
            d = 8'd62;
        end else if (c == CHAR_SLASH) begin
            d = 8'd63;
        end else begin
            bad = 1'b1;
        end
        return {bad, d[5:0]};
    endfunction

    // Hex digit lookup, either case: bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        logic [7:0] d;
        logic       bad;
        d   = 8'd0;
        bad = 1'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h41 + 8'd10;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h61 + 8'd10;
        end else begin
            bad = 1'b1;
        end
        return {bad, d[3:0]};
    endfunction

endpackage

// ===== hdl/hb64_decode.sv =====
// Per-character decode stage: mode register, quad/nibble state and the
// logic that turns one character into a result group. Uses hb64_pkg.
module hb64_decode
    import hb64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_data,
    input  logic       char_take,
    input  logic [7:0] char_data,
    input  logic       char_last,
    output logic       group_push,
    output group_t     group_data
);

    logic [1:0]      mode_reg;
    logic [2:0][5:0] hold_reg, hold_next;
    logic [1:0]      pos_reg, pos_next;
    logic [1:0]      pad_reg, pad_next;
    logic [1:0]      err_reg, err_next;

    logic [6:0] b64;
    logic [4:0] hx;
    logic       is_pad;
    logic [1:0] pos_inc;
    logic [5:0] s3;
    logic [1:0] nbytes;
    logic [2:0][7:0] bytes;
    logic [1:0] status;

    // Decode of the current character against the held state.
    always_comb begin
        hold_next = hold_reg;
        pos_next  = pos_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        b64       = b64_lookup(char_data);
        hx        = hex_lookup(char_data);
        is_pad    = (char_data == CHAR_PAD);
        pos_inc   = pos_reg + 2'd1;
        s3        = 6'd0;
        nbytes    = 2'd0;
        bytes     = '0;
        status    = STATUS_OK;

        unique case (mode_reg)
            MODE_BASE64: begin
                if (is_pad) begin
                    // Padding only in the last two places of the final quad.
                    if (pos_reg < 2'd2 || (pos_reg == 2'd2 && pad_reg != 2'd0) ||
                        (pos_reg == 2'd3 && pad_reg > 2'd1)) begin
                        err_next = STATUS_BAD_CHAR;
                    end else begin
                        pad_next = pad_reg + 2'd1;
                        if (pos_reg == 2'd2) begin
                            hold_next[2] = 6'd0;
                        end
                    end
                end else if (b64[6] || pad_reg != 2'd0) begin
                    err_next = STATUS_BAD_CHAR;
                end else if (pos_reg != 2'd3) begin
                    hold_next[pos_reg] = b64[5:0];
                end
                // A completed quad yields one to three bytes.
                if (pos_reg == 2'd3 && err_next == STATUS_OK) begin
                    s3       = is_pad ? 6'd0 : b64[5:0];
                    bytes[0] = {hold_reg[0], hold_reg[1][5:4]};
                    bytes[1] = {hold_reg[1][3:0], hold_reg[2][5:2]};
                    bytes[2] = {hold_reg[2][1:0], s3};
                    nbytes   = 2'd3 - pad_next;
                end
                pos_next = pos_inc;
                if (char_last) begin
                    status = (pos_inc != 2'd0) ? STATUS_BAD_LENGTH : err_next;
                end
            end
            MODE_HEX: begin
                if (hx[4]) begin
                    err_next = STATUS_BAD_CHAR;
                end else if (!pos_reg[0]) begin
                    hold_next[0] = {2'b00, hx[3:0]};
                end
                // The second digit of a pair completes a byte.
                if (pos_reg[0] && err_next == STATUS_OK) begin
                    bytes[0] = {hold_reg[0][3:0], hx[3:0]};
                    nbytes   = 2'd1;
                end
                pos_next = pos_inc;
                if (char_last) begin
                    status = pos_inc[0] ? STATUS_BAD_LENGTH : err_next;
                end
            end
            default: begin
                bytes[0] = char_data;
                nbytes   = 2'd1;
            end
        endcase

        // The end of a value clears all per-value state.
        if (char_last) begin
            hold_next = '0;
            pos_next  = 2'd0;
            pad_next  = 2'd0;
            err_next  = STATUS_OK;
        end
    end

    // Result group handed to the queue; a value end always makes one.
    always_comb begin
        group_push           = char_take && (nbytes != 2'd0 || char_last);
        group_data.bytes     = bytes;
        group_data.beats     = (nbytes == 2'd0) ? 2'd1 : nbytes;
        group_data.has_byte  = (nbytes != 2'd0);
        group_data.value_end = char_last;
        group_data.status    = status;
    end

    // Mode register and per-value state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
            hold_reg <= '0;
            pos_reg  <= 2'd0;
            pad_reg  <= 2'd0;
            err_reg  <= STATUS_OK;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (char_take) begin
                hold_reg <= hold_next;
                pos_reg  <= pos_next;
                pad_reg  <= pad_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

// ===== hdl/hb64_result_queue.sv =====
// Small queue of result groups and the serializer that sends each group
// out one byte per beat. Uses hb64_pkg.
module hb64_result_queue
    import hb64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       group_push,
    input  group_t     group_data,
    output logic       space,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [2:0] m_tuser
);

    group_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [1:0]        idx_reg;

    group_t head;
    logic   final_beat;
    logic   pop;

    // Output beat taken from the head group at the current byte index.
    always_comb begin
        head       = slots_reg[rd_ptr_reg];
        final_beat = (idx_reg == head.beats - 2'd1);
        m_tvalid   = (count_reg != '0);
        m_tdata    = head.has_byte ? head.bytes[idx_reg] : 8'd0;
        m_tlast    = head.value_end && final_beat;
        m_tuser    = {(m_tlast ? head.status : STATUS_OK), head.has_byte};
        pop        = m_tvalid && m_tready && final_beat;
        space      = (count_reg != QCNT_W'(QUEUE_DEPTH));
    end

    // Group storage, written at the tail.
    always_ff @(posedge aclk) begin
        if (group_push) begin
            slots_reg[wr_ptr_reg] <= group_data;
        end
    end

    // Pointers, fill count and byte index within the head group.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= 2'd0;
        end else begin
            if (group_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
                idx_reg    <= 2'd0;
            end else if (m_tvalid && m_tready) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (group_push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !group_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/hex_base64_value_decoder.sv =====
// Top level of the hex/base64 value decoder: decode stage and result queue.
// Depends on hb64_pkg, hb64_decode and hb64_result_queue.
//
// Usage: a value is streamed in one ASCII character per s_ beat, with
// s_tlast on its final character. Each beat yields zero to three m_ beats
// carrying decoded bytes; the final m_ beat of a value has m_tlast set and
// reports the status in m_tuser[2:1]. On a nonzero status the consumer
// drops every byte already received for that value. A value whose last
// character yields no byte ends with a beat whose has_byte flag is low.
// The mode is written on the cfg_ channel between values.
// The result group of an accepted beat is registered in the result queue
// before it is offered. Throughput: one character per cycle in while the queue
// has space, one byte per cycle out while m_tready is high; a base64 quad
// sends its bytes one per beat. A four-group result queue decouples the
// sides, and s_tready drops only while that queue is full, so a stalled
// receiver backs the input up after four pending groups.
// Reset: the mode returns to base64, per-value state clears and the queue
// empties.
module hex_base64_value_decoder
    import hb64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration: decode_mode.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    // Input characters.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // char_last
    // Decoded results.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_out
    output logic       m_tlast,   // value_end
    output logic [2:0] m_tuser    // [0] has_byte, [2:1] status
);

    logic   char_take;
    logic   group_push;
    group_t group_data;
    logic   space;

    // A character beat is taken whenever the queue has a free group slot.
    assign cfg_ready = 1'b1;
    assign s_tready  = space;
    assign char_take = s_tvalid && space;

    hb64_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .char_take  (char_take),
        .char_data  (s_tdata),
        .char_last  (s_tlast),
        .group_push (group_push),
        .group_data (group_data)
    );

    hb64_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .group_push (group_push),
        .group_data (group_data),
        .space      (space),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== hdl/hb64_checker.sv =====
// Port-level checks for the hex/base64 value decoder, bound to the top.
// Depends on hex_base64_value_decoder.
module hb64_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    // Reset empties the result queue.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat offered right after reset");

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result beat changed");

    // A beat without data exists only to close a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
        else $error("empty result beat that does not end a value");

    // Status is reported on the final beat only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'd0)
        else $error("status on a beat that does not end a value");

    // The unused status code never appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:1] != 2'd3)
        else $error("undefined status code");

endmodule

bind hex_base64_value_decoder hb64_checker u_checker (.*);
